// File: rtl/spq_pkg.sv
// Package for the sorted priority queue: key width, operation and status codes,
// and the control word broadcast from the top level to every storage cell.
// No dependencies.
package spq_pkg;

  localparam int KEY_BITS = 32;

  // Operation code carried in the mode field of an input word
  typedef enum logic {
    MODE_PUSH = 1'b0,
    MODE_POP  = 1'b1
  } mode_t;

  // Result status code
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Broadcast to all cells in the cycle a word is accepted
  typedef struct packed {
    logic                       push;
    logic                       pop;
    logic signed [KEY_BITS-1:0] key;
  } cell_ctl_t;

endpackage

// File: rtl/spq_in_if.sv
// Input channel of the sorted priority queue: valid/ready plus one operation word.
// Depends on spq_pkg.
interface spq_in_if import spq_pkg::*; #(
  parameter int PAYLOAD_BITS = 16
);
  logic                       valid;
  logic                       ready;
  logic                       mode;
  logic signed [KEY_BITS-1:0] key;
  logic [PAYLOAD_BITS-1:0]    payload;

  modport source (output valid, output mode, output key, output payload, input ready);
  modport sink   (input valid, input mode, input key, input payload, output ready);
endinterface

// File: rtl/spq_out_if.sv
// Result channel of the sorted priority queue: valid/ready plus one result word.
// Depends on spq_pkg.
interface spq_out_if import spq_pkg::*; #(
  parameter int PAYLOAD_BITS = 16,
  parameter int COUNT_BITS   = 5
);
  logic                       valid;
  logic                       ready;
  logic signed [KEY_BITS-1:0] out_key;
  logic [PAYLOAD_BITS-1:0]    out_payload;
  logic                       popped;
  logic [1:0]                 status;
  logic signed [KEY_BITS-1:0] top_key;
  logic                       top_valid;
  logic [COUNT_BITS-1:0]      count;

  modport source (output valid, output out_key, output out_payload, output popped,
                  output status, output top_key, output top_valid, output count,
                  input ready);
  modport sink   (input valid, input out_key, input out_payload, input popped,
                  input status, input top_key, input top_valid, input count,
                  output ready);
endinterface

// File: rtl/spq_cell.sv
// One storage cell of the sorted chain: holds a key and payload, and on each
// accepted word keeps, takes the new entry, or shifts from a neighbor. Depends on spq_pkg.
module spq_cell import spq_pkg::*; #(
  parameter int PAYLOAD_BITS = 16
) (
  input  logic                       clk,
  input  cell_ctl_t                  ctl,
  input  logic [PAYLOAD_BITS-1:0]    new_payload,
  input  logic                       occupied,
  input  logic                       left_keep,
  input  logic signed [KEY_BITS-1:0] left_key,
  input  logic [PAYLOAD_BITS-1:0]    left_payload,
  input  logic signed [KEY_BITS-1:0] right_key,
  input  logic [PAYLOAD_BITS-1:0]    right_payload,
  output logic                       keep,
  output logic signed [KEY_BITS-1:0] key_q,
  output logic [PAYLOAD_BITS-1:0]    payload_q
);

  logic signed [KEY_BITS-1:0] key_r, key_nxt;
  logic [PAYLOAD_BITS-1:0]    payload_r, payload_nxt;

  // Stored entry stays in place on a push if its key is >= the new key
  assign keep = occupied && (key_r >= ctl.key);

  // Next entry: hold, insert new, shift down from left, or shift up from right
  always_comb begin
    key_nxt     = key_r;
    payload_nxt = payload_r;
    if (ctl.push && !keep) begin
      if (left_keep) begin
        key_nxt     = ctl.key;
        payload_nxt = new_payload;
      end else begin
        key_nxt     = left_key;
        payload_nxt = left_payload;
      end
    end else if (ctl.pop) begin
      key_nxt     = right_key;
      payload_nxt = right_payload;
    end
  end

  always_ff @(posedge clk) begin
    key_r     <= key_nxt;
    payload_r <= payload_nxt;
  end

  assign key_q     = key_r;
  assign payload_q = payload_r;

endmodule

// File: rtl/sorted_priority_queue_top.sv
// Top level of the sorted priority queue: a chain of spq_cell storage cells,
// an entry counter and a registered result stage. Depends on spq_pkg, spq_cell,
// spq_in_if and spq_out_if.
//   channel  dir  handshake           word
//   in_if    in   valid/ready         mode, key, payload
//   out_if   out  valid/ready         out_key, out_payload, popped, status,
//                                     top_key, top_valid, count
//
// All cells compare the new key against their own in parallel and shift or load in
// the accept cycle; the result is registered. A new word is accepted while the result
// register is empty or being drained. Synchronous active-low reset empties the queue
// and the result register; no clearing pass is needed, cell contents beyond the count
// are never read.
module sorted_priority_queue_top import spq_pkg::*; #(
  parameter int DEPTH        = 16,
  parameter int PAYLOAD_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  spq_in_if.sink    in_if,
  spq_out_if.source out_if
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_vld_r, out_vld_nxt;

  logic signed [KEY_BITS-1:0] out_key_r;
  logic [PAYLOAD_BITS-1:0]    out_payload_r;
  logic                       out_popped_r;
  status_t                    out_status_r;
  logic signed [KEY_BITS-1:0] out_top_key_r;
  logic                       out_top_valid_r;
  logic [CNT_W-1:0]           out_count_r;

  logic accept, is_push, full, empty, do_push, do_pop;
  cell_ctl_t ctl;
  logic signed [KEY_BITS-1:0] head_nxt;
  status_t status_nxt;

  logic                       keeps    [DEPTH];
  logic signed [KEY_BITS-1:0] cell_key [DEPTH];
  logic [PAYLOAD_BITS-1:0]    cell_pay [DEPTH];

  // Handshake and operation decode
  assign in_if.ready = !out_vld_r || out_if.ready;
  assign accept      = in_if.valid && in_if.ready;
  assign is_push     = (in_if.mode == MODE_PUSH);
  assign full        = (count_r == CNT_W'(DEPTH));
  assign empty       = (count_r == '0);
  assign do_push     = accept && is_push && !full;
  assign do_pop      = accept && !is_push && !empty;

  assign ctl.push = do_push;
  assign ctl.pop  = do_pop;
  assign ctl.key  = in_if.key;

  // Cell chain; cell 0 holds the head
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                       lkeep;
    logic signed [KEY_BITS-1:0] lkey, rkey;
    logic [PAYLOAD_BITS-1:0]    lpay, rpay;

    if (i == 0) begin : g_first
      assign lkeep = 1'b1;
      assign lkey  = in_if.key;
      assign lpay  = in_if.payload;
    end else begin : g_mid
      assign lkeep = keeps[i-1];
      assign lkey  = cell_key[i-1];
      assign lpay  = cell_pay[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign rkey = cell_key[i];
      assign rpay = cell_pay[i];
    end else begin : g_inner
      assign rkey = cell_key[i+1];
      assign rpay = cell_pay[i+1];
    end

    spq_cell #(.PAYLOAD_BITS(PAYLOAD_BITS)) u_cell (
      .clk           (clk),
      .ctl           (ctl),
      .new_payload   (in_if.payload),
      .occupied      (CNT_W'(i) < count_r),
      .left_keep     (lkeep),
      .left_key      (lkey),
      .left_payload  (lpay),
      .right_key     (rkey),
      .right_payload (rpay),
      .keep          (keeps[i]),
      .key_q         (cell_key[i]),
      .payload_q     (cell_pay[i])
    );
  end

  // Count and head key after the operation
  always_comb begin
    count_nxt = count_r;
    head_nxt  = cell_key[0];
    if (do_push) begin
      count_nxt = count_r + CNT_W'(1);
      head_nxt  = keeps[0] ? cell_key[0] : in_if.key;
    end else if (do_pop) begin
      count_nxt = count_r - CNT_W'(1);
      head_nxt  = cell_key[1];
    end
  end

  // Status of the accepted word
  always_comb begin
    status_nxt = ST_OK;
    if (accept && is_push && full) begin
      status_nxt = ST_FULL;
    end else if (accept && !is_push && empty) begin
      status_nxt = ST_EMPTY;
    end
  end

  // Result register valid
  always_comb begin
    out_vld_nxt = out_vld_r;
    if (accept) begin
      out_vld_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      out_vld_r <= 1'b0;
    end else begin
      count_r   <= count_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Result word, loaded on accept
  always_ff @(posedge clk) begin
    if (accept) begin
      out_key_r       <= do_pop ? cell_key[0] : '0;
      out_payload_r   <= do_pop ? cell_pay[0] : '0;
      out_popped_r    <= do_pop;
      out_status_r    <= status_nxt;
      out_top_key_r   <= (count_nxt != '0) ? head_nxt : '0;
      out_top_valid_r <= (count_nxt != '0);
      out_count_r     <= count_nxt;
    end
  end

  assign out_if.valid       = out_vld_r;
  assign out_if.out_key     = out_key_r;
  assign out_if.out_payload = out_payload_r;
  assign out_if.popped      = out_popped_r;
  assign out_if.status      = out_status_r;
  assign out_if.top_key     = out_top_key_r;
  assign out_if.top_valid   = out_top_valid_r;
  assign out_if.count       = out_count_r;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_pop_dec: assert property (@(posedge clk) disable iff (!rst_n)
    do_pop |=> count_r == $past(count_r) - CNT_W'(1))
    else $error("pop did not decrement count");

  a_push_inc: assert property (@(posedge clk) disable iff (!rst_n)
    do_push |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("push did not increment count");

  a_popped_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_popped_r) |-> (out_status_r == ST_OK && out_top_valid_r ==
      (out_count_r != '0)))
    else $error("popped result with error status or bad head flag");

endmodule

// File: dv/tb.sv
// Self-checking testbench for sorted_priority_queue_top: drives push/pop words,
// predicts every result word from a shadow sorted store and compares field by field.
// Depends on spq_pkg, spq_in_if, spq_out_if and the queue RTL.
module tb;
  import spq_pkg::*;

  localparam int DEPTH        = 16;
  localparam int PAYLOAD_BITS = 16;
  localparam int COUNT_BITS   = 5;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 150;

  typedef struct {
    logic signed [KEY_BITS-1:0] out_key;
    logic [PAYLOAD_BITS-1:0]    out_payload;
    logic                       popped;
    status_t                    status;
    logic signed [KEY_BITS-1:0] top_key;
    logic                       top_valid;
    logic [COUNT_BITS-1:0]      count;
  } result_t;

  logic clk = 1'b0;
  logic rst_n;

  spq_in_if  #(.PAYLOAD_BITS(PAYLOAD_BITS)) in_ch ();
  spq_out_if #(.PAYLOAD_BITS(PAYLOAD_BITS), .COUNT_BITS(COUNT_BITS)) out_ch ();

  sorted_priority_queue_top #(
    .DEPTH        (DEPTH),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow copy of the sorted store, largest key at index 0
  logic signed [KEY_BITS-1:0] shadow_keys [DEPTH];
  logic [PAYLOAD_BITS-1:0]    shadow_pays [DEPTH];
  int                         shadow_count = 0;

  result_t pending_results [$];
  int      mismatches   = 0;
  int      snd_idle_pct = 0;
  int      rcv_idle_pct = 0;
  int      hold_req     = 0;
  int      hold_ack     = 0;
  int      hold_left    = 0;
  int      cycle_cnt    = 0;

  // Apply one accepted word to the shadow store and queue the result it must give
  function automatic void apply_queue_op(mode_t m, logic signed [KEY_BITS-1:0] k,
                                         logic [PAYLOAD_BITS-1:0] p);
    result_t r;
    int      pos;
    r.out_key     = '0;
    r.out_payload = '0;
    r.popped      = 1'b0;
    r.status      = ST_OK;
    if (m == MODE_PUSH) begin
      if (shadow_count >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        // new entry goes behind every key >= its own
        pos = 0;
        while (pos < shadow_count && shadow_keys[pos] >= k) pos++;
        for (int i = shadow_count; i > pos; i--) begin
          shadow_keys[i] = shadow_keys[i-1];
          shadow_pays[i] = shadow_pays[i-1];
        end
        shadow_keys[pos] = k;
        shadow_pays[pos] = p;
        shadow_count++;
      end
    end else begin
      if (shadow_count == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.out_key     = shadow_keys[0];
        r.out_payload = shadow_pays[0];
        r.popped      = 1'b1;
        for (int i = 1; i < shadow_count; i++) begin
          shadow_keys[i-1] = shadow_keys[i];
          shadow_pays[i-1] = shadow_pays[i];
        end
        shadow_count--;
      end
    end
    r.top_valid = (shadow_count > 0);
    r.top_key   = (shadow_count > 0) ? shadow_keys[0] : '0;
    r.count     = shadow_count[COUNT_BITS-1:0];
    pending_results.push_back(r);
  endfunction

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Offer one word after random idling; returns at the accepting edge
  task automatic send_word(mode_t m, logic signed [KEY_BITS-1:0] k,
                           logic [PAYLOAD_BITS-1:0] p);
    while (snd_idle_pct != 0 && $urandom_range(99) < snd_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.mode    <= m;
    in_ch.key     <= k;
    in_ch.payload <= p;
    do @(posedge clk); while (!in_ch.ready);
    apply_queue_op(m, k, p);
  endtask

  // Random key: 40% a narrow band to force ties, 10% extremes, rest full range
  function automatic logic signed [KEY_BITS-1:0] pick_key();
    int sel;
    int kv;
    sel = $urandom_range(99);
    if (sel < 40) begin
      kv = int'($urandom_range(6)) - 3;
      return kv;
    end else if (sel < 50) begin
      case ($urandom_range(3))
        0: return 32'sh7fffffff;
        1: return 32'sh80000000;
        2: return 32'sh0;
        default: return -32'sd1;
      endcase
    end
    return $urandom;
  endfunction

  // Pop from empty, fill with corner keys and ties, push once more while full, then pop a few
  task automatic test_corner_cases();
    logic signed [KEY_BITS-1:0] corner_keys [DEPTH];
    corner_keys = '{32'sh7fffffff, 32'sh80000000, 0, 0, 0, -1, 1, 32'sh7fffffff,
                    32'sh80000000, 100, -100, 7, 7, 32'sh55555555, 32'shaaaaaaaa, 2};
    send_word(MODE_POP, 0, 0);
    for (int i = 0; i < DEPTH; i++) begin
      send_word(MODE_PUSH, corner_keys[i],
                (i == 0) ? 16'hffff : (i == 1) ? 16'h0000 : PAYLOAD_BITS'($urandom));
    end
    send_word(MODE_PUSH, 32'sh7fffffff, 16'hffff);
    repeat (5) send_word(MODE_POP, $urandom, PAYLOAD_BITS'($urandom));
  endtask

  // Random push/pop mix; the push share shifts every 32 words to sweep full and empty
  task automatic test_random_traffic(int n);
    int push_pct;
    push_pct = 50;
    for (int i = 0; i < n; i++) begin
      if (i % 32 == 0) begin
        case ($urandom_range(2))
          0: push_pct = 80;
          1: push_pct = 20;
          default: push_pct = 50;
        endcase
      end
      if ($urandom_range(99) < push_pct) begin
        send_word(MODE_PUSH, pick_key(), PAYLOAD_BITS'($urandom));
      end else begin
        send_word(MODE_POP, $urandom, PAYLOAD_BITS'($urandom));
      end
    end
  endtask

  // Receiver holds off a long stretch while words keep coming, stalling the input
  task automatic test_backpressure();
    hold_req <= hold_req + 1;
    for (int i = 0; i < 40; i++) begin
      if (i % 4 == 3) send_word(MODE_POP, $urandom, PAYLOAD_BITS'($urandom));
      else send_word(MODE_PUSH, pick_key(), PAYLOAD_BITS'($urandom));
    end
  endtask

  // Receiver: random ready, or forced low during a hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_req != hold_ack) begin
      hold_ack     <= hold_req;
      hold_left    <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // Result checker: each accepted word against the oldest expectation
  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result word arrived with nothing expected");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("out_key", want.out_key, out_ch.out_key);
        check_field("out_payload", want.out_payload, out_ch.out_payload);
        check_field("popped", want.popped, out_ch.popped);
        check_field("status", want.status, out_ch.status);
        check_field("top_key", want.top_key, out_ch.top_key);
        check_field("top_valid", want.top_valid, out_ch.top_valid);
        check_field("count", want.count, out_ch.count);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAIL sorted_priority_queue_top");
      $finish;
    end
  end

  initial begin
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.mode    <= MODE_PUSH;
    in_ch.key     <= '0;
    in_ch.payload <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // sender idles more lightly than the receiver
    snd_idle_pct = 37;
    rcv_idle_pct = 47;
    test_corner_cases();
    test_random_traffic(600);
    test_backpressure();

    // roles swapped
    snd_idle_pct = 47;
    rcv_idle_pct = 37;
    test_random_traffic(650);

    // full rate both sides
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    test_random_traffic(600);
    test_backpressure();

    // drain outstanding results, then settle
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (mismatches == 0) begin
      $display("PASS sorted_priority_queue_top");
    end else begin
      $display("FAIL sorted_priority_queue_top");
    end
    $finish;
  end

endmodule
